// File: hdl/tqla_pkg.sv
// Shared types, codes and value-table helpers for the tabular Q-learning agent.
package tqla_pkg;

   localparam logic [0:0] ACT_CHOOSE = 1'b0;
   localparam logic [0:0] ACT_LEARN  = 1'b1;

   localparam logic [1:0] MOVE_STAY  = 2'd0;
   localparam logic [1:0] MOVE_LEFT  = 2'd1;
   localparam logic [1:0] MOVE_RIGHT = 2'd2;
   localparam logic [1:0] MOVE_BAD   = 2'd3;

   localparam logic [0:0] CSR_GAMMA = 1'b0;
   localparam logic [0:0] CSR_ALPHA = 1'b1;

   localparam logic [16:0] GAMMA_RESET = 17'd58982;
   localparam logic [15:0] ALPHA_RESET = 16'd66;
   localparam logic signed [31:0] Q_RESET = 32'sd21845;
   localparam logic [16:0] ONE_Q16 = 17'h10000;
   localparam int GREEDY_SCALE = 1000;

   typedef struct packed {
      logic [0:0]         action;
      logic [12:0]        position;
      logic signed [15:0] velocity;
      logic [12:0]        next_position;
      logic signed [15:0] next_velocity;
      logic [1:0]         move;
      logic signed [15:0] reward;
      logic [9:0]         coin;
      logic [1:0]         random_move;
   } req_type;

   typedef struct packed {
      logic [1:0]         chosen_move;
      logic [0:0]         greedy;
      logic signed [31:0] new_value;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL1,
      ST_MUL2,
      ST_WB
   } state_type;

   typedef struct packed {
      logic mul1_en;
      logic mul2_en;
   } upd_ctl_type;

   // ties go to left, then stay over right only when strictly greater
   function automatic logic [1:0] best_move(logic signed [31:0] s, logic signed [31:0] l,
                                            logic signed [31:0] r);
      logic [1:0] m;
      if (l >= s && l >= r) begin
         m = MOVE_LEFT;
      end else if (s > r) begin
         m = MOVE_STAY;
      end else begin
         m = MOVE_RIGHT;
      end
      return m;
   endfunction

   function automatic logic signed [31:0] max3(logic signed [31:0] s, logic signed [31:0] l,
                                               logic signed [31:0] r);
      logic signed [31:0] m;
      m = l;
      if (s > m) begin
         m = s;
      end
      if (r > m) begin
         m = r;
      end
      return m;
   endfunction

endpackage

// File: hdl/tqla_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module tqla_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/tqla_store.sv
// Stay, left and right value tables with per-entry valid bits for the reset value.
module tqla_store #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic                     wr_en,
   input  logic [1:0]               wr_sel,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic signed [31:0]       wr_data,
   output logic signed [31:0]       rd_stay,
   output logic signed [31:0]       rd_left,
   output logic signed [31:0]       rd_right
);
   import tqla_pkg::*;

   logic [DEPTH-1:0] vld_stay_ff, vld_left_ff, vld_right_ff;
   logic [2:0]       rvld_ff;
   logic             we_stay, we_left, we_right;
   logic [31:0]      ram_stay, ram_left, ram_right;

   assign we_stay  = wr_en && (wr_sel == MOVE_STAY);
   assign we_left  = wr_en && (wr_sel == MOVE_LEFT);
   assign we_right = wr_en && (wr_sel == MOVE_RIGHT);

   tqla_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_stay (
      .clock(clock), .wr_en(we_stay), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(ram_stay)
   );

   tqla_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_left (
      .clock(clock), .wr_en(we_left), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(ram_left)
   );

   tqla_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_right (
      .clock(clock), .wr_en(we_right), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(ram_right)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_stay_ff  <= '0;
         vld_left_ff  <= '0;
         vld_right_ff <= '0;
         rvld_ff      <= '0;
      end else begin
         if (we_stay) begin
            vld_stay_ff[wr_addr] <= 1'b1;
         end
         if (we_left) begin
            vld_left_ff[wr_addr] <= 1'b1;
         end
         if (we_right) begin
            vld_right_ff[wr_addr] <= 1'b1;
         end
         rvld_ff <= {vld_right_ff[rd_addr], vld_left_ff[rd_addr], vld_stay_ff[rd_addr]};
      end
   end

   assign rd_stay  = rvld_ff[0] ? $signed(ram_stay)  : Q_RESET;
   assign rd_left  = rvld_ff[1] ? $signed(ram_left)  : Q_RESET;
   assign rd_right = rvld_ff[2] ? $signed(ram_right) : Q_RESET;

endmodule

// File: hdl/tqla_update.sv
// Two-stage multiply datapath for the Q-value update with 32-bit saturation.
module tqla_update (
   input  logic                  clock,
   input  tqla_pkg::upd_ctl_type ctl,
   input  logic [16:0]           gamma,
   input  logic [15:0]           alpha,
   input  logic signed [15:0]    reward,
   input  logic signed [31:0]    maxq,
   input  logic signed [31:0]    qold,
   output logic signed [31:0]    value
);
   import tqla_pkg::*;

   logic signed [17:0] gam_s;
   logic signed [17:0] alpha_s;
   logic signed [17:0] keep_s;
   logic signed [49:0] gm_in, gm_ff;
   logic signed [31:0] qold_ff;
   logic signed [34:0] target;
   logic signed [51:0] pnew_in, pnew_ff;
   logic signed [49:0] pold_in, pold_ff;
   logic signed [52:0] sum;
   logic signed [36:0] vfull;

   assign gam_s   = $signed({1'b0, gamma});
   assign alpha_s = $signed({2'b00, alpha});
   assign keep_s  = $signed({1'b0, ONE_Q16 - {1'b0, alpha}});

   assign gm_in = gam_s * maxq;

   always_ff @(posedge clock) begin
      if (ctl.mul1_en) begin
         gm_ff   <= gm_in;
         qold_ff <= qold;
      end
   end

   // target = reward * 2^16 + floor(gamma * maxq / 2^16)
   assign target  = 35'($signed({reward, 16'h0000})) + 35'(gm_ff >>> 16);
   assign pnew_in = alpha_s * target;
   assign pold_in = keep_s * qold_ff;

   always_ff @(posedge clock) begin
      if (ctl.mul2_en) begin
         pnew_ff <= pnew_in;
         pold_ff <= pold_in;
      end
   end

   assign sum   = 53'(pnew_ff) + 53'(pold_ff);
   assign vfull = 37'(sum >>> 16);

   always_comb begin
      if (vfull[36:31] == 6'b000000 || vfull[36:31] == 6'b111111) begin
         value = vfull[31:0];
      end else if (vfull[36]) begin
         value = 32'sh8000_0000;
      end else begin
         value = 32'sh7FFF_FFFF;
      end
   end

endmodule

// File: hdl/tabular_q_learning_agent_top.sv
// Tabular Q-learning agent: epsilon-greedy move choice and table update.
//
//   channel | ports                          | direction | moves
//   --------+--------------------------------+-----------+---------------------------
//   req     | req_valid, req_stall, req_data | in        | choose or learn item
//   rsp     | rsp_valid, rsp_stall, rsp_data | out       | chosen move / new value
//   csr     | csr_we, csr_index, csr_wdata   | in        | gamma (0), alpha (1)
//
// A choose item passes through accept and evaluate; a learn item also through MUL1, MUL2
// and write-back, and the result is registered as the item leaves its last state. Learn:
// one table read at the next state, one at the current state, two multiply stages and a
// write-back through the single read port of each table memory.
// Reset clears the per-entry valid bits; no sweep is needed.
// req_stall is high while an item is in flight; a stalled result holds the final
// state (and the table write) until the output register is free.
module tabular_q_learning_agent_top #(
   parameter int POS_CELLS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tqla_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tqla_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [16:0]       csr_wdata
);
   import tqla_pkg::*;

   localparam int DEPTH = 2 * POS_CELLS;
   localparam int AW    = $clog2(DEPTH);

   state_type   state_ff, state_in;
   upd_ctl_type ctl;

   logic [16:0]        gamma_ff;
   logic [15:0]        alpha_ff;
   logic [0:0]         act_ff;
   logic [1:0]         move_ff;
   logic [1:0]         rmove_ff;
   logic signed [15:0] reward_ff;
   logic               greedy_ff;
   logic [AW-1:0]      idx_ff;
   logic signed [31:0] maxq_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept, maxq_load, wr_en, rsp_load, out_free;
   logic [AW-1:0]      idx_c, nidx_c, rd_addr;
   logic               greedy_c;
   logic signed [31:0] q_stay, q_left, q_right, qold, upd_value;

   function automatic logic [AW-1:0] state_idx(logic [12:0] pos, logic signed [15:0] vel);
      logic [8:0] pos_cell;
      logic [8:0] lim;
      logic       vbit;
      pos_cell = {4'b0000, pos[12:8]};
      lim      = 9'(POS_CELLS - 1);
      vbit     = !vel[15] && (vel != 16'sd0);
      if (pos_cell > lim) begin
         pos_cell = lim;
      end
      return AW'({pos_cell, vbit});
   endfunction

   assign idx_c    = state_idx(req_data.position, req_data.velocity);
   assign nidx_c   = state_idx(req_data.next_position, req_data.next_velocity);
   assign greedy_c = (27'(gamma_ff) * 27'(GREEDY_SCALE)) > {1'b0, req_data.coin, 16'h0000};

   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_addr   = (state_ff == ST_IDLE) ?
                      ((req_data.action == ACT_LEARN) ? nidx_c : idx_c) : idx_ff;

   tqla_store #(.DEPTH(DEPTH)) u_store (
      .clock(clock), .reset(reset), .rd_addr(rd_addr),
      .wr_en(wr_en), .wr_sel(move_ff), .wr_addr(idx_ff), .wr_data(upd_value),
      .rd_stay(q_stay), .rd_left(q_left), .rd_right(q_right)
   );

   always_comb begin
      case (move_ff)
         MOVE_LEFT:  qold = q_left;
         MOVE_RIGHT: qold = q_right;
         default:    qold = q_stay;
      endcase
   end

   tqla_update u_update (
      .clock(clock), .ctl(ctl), .gamma(gamma_ff), .alpha(alpha_ff), .reward(reward_ff),
      .maxq(maxq_ff), .qold(qold), .value(upd_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gamma_ff     <= GAMMA_RESET;
         alpha_ff     <= ALPHA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_GAMMA: gamma_ff <= csr_wdata;
               CSR_ALPHA: alpha_ff <= csr_wdata[15:0];
               default:   gamma_ff <= gamma_ff;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff    <= req_data.action;
         move_ff   <= req_data.move;
         rmove_ff  <= req_data.random_move;
         reward_ff <= req_data.reward;
         greedy_ff <= greedy_c;
         idx_ff    <= idx_c;
      end
      if (maxq_load) begin
         maxq_ff <= max3(q_stay, q_left, q_right);
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      accept    = 1'b0;
      maxq_load = 1'b0;
      ctl       = '0;
      wr_en     = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               accept   = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (act_ff == ACT_LEARN) begin
               maxq_load = 1'b1;
               state_in  = ST_MUL1;
            end else if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MUL1: begin
            ctl.mul1_en = 1'b1;
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            ctl.mul2_en = 1'b1;
            state_in    = ST_WB;
         end
         ST_WB: begin
            if (out_free) begin
               rsp_load = 1'b1;
               wr_en    = (move_ff != MOVE_BAD);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_data_in = '0;
      if (state_ff == ST_EVAL) begin
         rsp_data_in.greedy = greedy_ff;
         if (greedy_ff) begin
            rsp_data_in.chosen_move = best_move(q_stay, q_left, q_right);
         end else if (rmove_ff == MOVE_BAD) begin
            rsp_data_in.chosen_move = MOVE_RIGHT;
         end else begin
            rsp_data_in.chosen_move = rmove_ff;
         end
      end else if (move_ff != MOVE_BAD) begin
         rsp_data_in.new_value = upd_value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_wr_only_wb: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_WB) && rsp_load)
      else $error("table write outside write-back");

   a_no_bad_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (act_ff == ACT_LEARN) && (move_ff != MOVE_BAD))
      else $error("table write for invalid move");

   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EVAL))
      else $error("transfer did not start evaluation");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwrote a stalled transfer");

   a_learn_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && act_ff == ACT_LEARN) |=> (state_ff == ST_MUL1) ##1
      (state_ff == ST_MUL2) ##1 (state_ff == ST_WB))
      else $error("learn sequence broken");

endmodule
